// ===== rtl/rks_pkg.sv =====
package rks_pkg;

  localparam int KEY_MAX_DEFAULT = 56;
  localparam int CHAR_W = 8;
  localparam int KEY_LEN_W = 6;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W = 64;
  localparam int REC_NUM_W = 16;

  localparam logic [CFG_INDEX_W-1:0] REG_KEY_LENGTH  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_KEY_CHARS_0 = 3'd1;

  localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [CHAR_W-1:0] CASE_OFFSET  = 8'h20;
  localparam logic [CHAR_W-1:0] CHAR_NUL     = 8'h00;

  typedef struct packed {
    logic [CHAR_W-1:0] text_char;
    logic              has_char;
    logic              last_of_field;
    logic              last_of_record;
  } in_item_t;

  function automatic logic [CHAR_W-1:0] fold_case(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] r;
    r = c;
    if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
      r = c + CASE_OFFSET;
    end
    return r;
  endfunction

endpackage

// ===== rtl/record_keyword_search.sv =====
// A record-ending beat passes the input item register; its result is then registered out.
// Throughput: one character beat per cycle, unless a record end waits on a stalled result.
// The keyword comparators work on all key positions in parallel against each beat.
// Reset (synchronous, active high) clears the keyword, the match state and the record count.
// No clearing pass is needed; the block takes beats in the first cycle after reset.
module record_keyword_search
  import rks_pkg::*;
#(
  parameter int KEY_MAX = KEY_MAX_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [CHAR_W-1:0]      s_tdata,   // text_char
  input  logic [1:0]             s_tuser,   // has_char, last_of_field
  input  logic                   s_tlast,   // last_of_record
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [REC_NUM_W-1:0]   m_tdata,   // record_number
  output logic                   m_tuser,   // record_hit
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  logic [KEY_LEN_W-1:0] key_length;
  logic [CHAR_W-1:0]    key_fold [KEY_MAX];

  in_item_t             item;
  logic                 item_valid;

  logic [KEY_MAX-1:0]   partial_match;
  logic [KEY_MAX-1:0]   partial_match_next;
  logic                 record_hit_seen;
  logic                 record_hit_seen_next;
  logic [REC_NUM_W-1:0] record_counter;

  logic                 out_valid;
  logic [REC_NUM_W-1:0] out_number;
  logic                 out_hit;

  logic [KEY_MAX-1:0]   key_nonzero;
  logic [KEY_MAX-1:0]   key_use;
  logic [KEY_MAX-1:0]   key_last;
  logic [KEY_MAX-1:0]   char_eq;
  logic [KEY_MAX-1:0]   match_step;
  logic [CHAR_W-1:0]    char_fold;
  logic                 item_advance;
  logic                 key_empty;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_length <= '0;
      for (int j = 0; j < KEY_MAX; j++) begin
        key_fold[j] <= CHAR_NUL;
      end
    end else if (cfg_valid) begin
      if (cfg_index == REG_KEY_LENGTH) begin
        key_length <= cfg_data[KEY_LEN_W-1:0];
      end
      for (int j = 0; j < KEY_MAX; j++) begin
        if (cfg_index == CFG_INDEX_W'(int'(REG_KEY_CHARS_0) + (j >> 3))) begin
          key_fold[j] <= fold_case(cfg_data[CHAR_W*(j & 7) +: CHAR_W]);
        end
      end
    end
  end

  // Keyword positions in use: below key_length and before the first zero byte.
  always_comb begin
    for (int j = 0; j < KEY_MAX; j++) begin
      key_nonzero[j] = (key_fold[j] != CHAR_NUL);
    end
    for (int j = 0; j < KEY_MAX; j++) begin
      key_use[j] = (int'(key_length) > j) &&
                   ((key_nonzero | ~({KEY_MAX{1'b1}} >> (KEY_MAX - 1 - j))) == '1);
    end
    key_last  = key_use & ~(key_use >> 1);
    key_empty = !key_use[0];
  end

  assign char_fold = fold_case(item.text_char);

  always_comb begin
    for (int j = 0; j < KEY_MAX; j++) begin
      char_eq[j] = (key_fold[j] == char_fold);
    end
    match_step = ((partial_match << 1) | KEY_MAX'(1)) & char_eq & key_use;

    partial_match_next   = partial_match;
    record_hit_seen_next = record_hit_seen;
    if (item.has_char && !key_empty) begin
      partial_match_next = match_step;
      if ((match_step & key_last) != '0) begin
        record_hit_seen_next = 1'b1;
      end
    end
    if (item.last_of_field || item.last_of_record) begin
      partial_match_next = '0;
    end
  end

  assign item_advance = item_valid && (!item.last_of_record || !out_valid || m_tready);
  assign s_tready     = !item_valid || item_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (s_tready) begin
      item_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      item.text_char      <= s_tdata;
      item.has_char       <= s_tuser[0];
      item.last_of_field  <= s_tuser[1];
      item.last_of_record <= s_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      partial_match   <= '0;
      record_hit_seen <= 1'b0;
      record_counter  <= '0;
    end else if (item_advance) begin
      partial_match <= partial_match_next;
      if (item.last_of_record) begin
        record_hit_seen <= 1'b0;
        record_counter  <= record_counter + 1'b1;
      end else begin
        record_hit_seen <= record_hit_seen_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (item_advance && item.last_of_record) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_advance && item.last_of_record) begin
      out_number <= record_counter;
      out_hit    <= record_hit_seen_next || key_empty;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_number;
  assign m_tuser  = out_hit;

endmodule

// ===== rtl/rks_checker.sv =====
module rks_checker
  import rks_pkg::*;
(
  input logic                   clk,
  input logic                   rst,
  input logic                   s_tvalid,
  input logic                   s_tready,
  input logic                   s_tlast,
  input logic                   m_tvalid,
  input logic                   m_tready,
  input logic [REC_NUM_W-1:0]   m_tdata,
  input logic                   m_tuser
);

  logic [REC_NUM_W-1:0] expected_number;

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_number <= '0;
    end else if (m_tvalid && m_tready) begin
      expected_number <= expected_number + 1'b1;
    end
  end

  // A stalled result beat keeps its payload.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result beat changed while stalled");

  // Record numbers come out in order without gaps.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata == expected_number)
    else $error("record number out of sequence");

  // A fresh result is preceded by an accepted record-ending input beat.
  assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(s_tvalid && s_tready && s_tlast, 2))
    else $error("result without a record end");

  // No result is shown right after reset.
  assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind record_keyword_search rks_checker u_rks_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tlast  (s_tlast),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
